FILE: sv/arps_pkg.sv
// Shared constants, types and a helper function of the alignment pattern row scanner.
package arps_pkg;

  // Row geometry and run counter saturation
  localparam int ROW_WIDTH = 4096;
  localparam int RUN_W     = 12;
  localparam int RUN_CAP_I = ((ROW_WIDTH - 1) < 4095) ? (ROW_WIDTH - 1) : 4095;
  localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(RUN_CAP_I);

  // Field widths
  localparam int EDGE_W  = 16;
  localparam int X_W     = 12;
  localparam int SUM_W   = 14;
  localparam int SCORE_W = 8;
  localparam int FS_W    = 12;
  localparam int SIZE_W  = 12;
  localparam int DIFF_W  = 17;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINDER_SIZE = 1'b1;

  // Score weights
  localparam logic [SCORE_W-1:0] SCORE_SYM    = 8'd100;
  localparam logic [SCORE_W-1:0] SCORE_SIZE   = 8'd22;
  localparam logic [SCORE_W-1:0] SCORE_FINDER = 8'd50;

  // (sum + 1) / 3 as multiply by ceil(2^17 / 3) and shift
  localparam int RECIP3_W  = 16;
  localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;
  localparam int RECIP3_SH = 17;
  localparam int PROD_W    = SUM_W + RECIP3_W;

  // Candidate queue and result queue geometry
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 4);

  // One candidate: the three scored runs and the pixel that closed them
  typedef struct packed {
    logic [RUN_W-1:0] run_a;
    logic [RUN_W-1:0] run_b;
    logic [RUN_W-1:0] run_c;
    logic [X_W-1:0]   pixel_x;
  } cand_t;

  typedef struct packed {
    logic [SCORE_W-1:0] min_score;
    logic [FS_W-1:0]    finder_size;
  } cfg_t;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] x,
                                                 input logic [DIFF_W-1:0] y);
    abs_diff = (x > y) ? (x - y) : (y - x);
  endfunction

endpackage

FILE: sv/alignment_pattern_row_scanner.sv
// Top level of the alignment pattern row scanner: configuration registers and block wiring.
//
// Scans one row of signed edge responses, one pixel word per clock while full
// is low, for the rise-fall-rise-fall run pattern of a QR alignment pattern. A
// pixel is taken at every clock edge where push is high and full is low, so
// the block sustains one pixel per cycle while full is low; the combinational
// phase and run width update in the front end sets that rate. Each falling
// edge that closes a third run hands the three runs to a four-entry candidate
// queue; a three stage scoring pipeline (sum and centre, reciprocal multiply
// for the mean run size, score and verdict) follows, and passing candidates
// land in an eight-word result queue. A result word, having passed the
// candidate queue, stage registers and result queue, is on out_center_x and
// out_pattern_width while empty is low, and is taken with pop. Full rises
// only when the result side has been stalled long enough to back the
// candidate queue up. Write min_score (index 0) and finder_size (index 1)
// through cfg_we, cfg_index and cfg_wdata while the block is idle; both reset
// to zero. row_start clears phase and run widths before its own pixel.
module alignment_pattern_row_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [arps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arps_pkg::FS_W-1:0]          cfg_wdata,
  // pixel words
  input  logic                               push,
  output logic                               full,
  input  logic signed [arps_pkg::EDGE_W-1:0] in_edge_value,
  input  logic [arps_pkg::X_W-1:0]           in_pixel_x,
  input  logic                               in_row_start,
  // result words
  output logic                               empty,
  input  logic                               pop,
  output logic [arps_pkg::X_W-1:0]           out_center_x,
  output logic [arps_pkg::SUM_W-1:0]         out_pattern_width
);
  import arps_pkg::*;

  cfg_t  cfg_r;
  logic  in_accept;
  logic  cand_push, cand_pop, cand_empty;
  cand_t cand_wr, cand_rd;

  // Hold configuration; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SCORE:   cfg_r.min_score   <= cfg_wdata[SCORE_W-1:0];
        CFG_FINDER_SIZE: cfg_r.finder_size <= cfg_wdata;
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  // Accept a pixel whenever the candidate queue can take whatever it might raise
  assign in_accept = push && !full;

  arps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_accept),
    .edge_value (in_edge_value),
    .pixel_x    (in_pixel_x),
    .row_start  (in_row_start),
    .cand_valid (cand_push),
    .cand       (cand_wr)
  );

  arps_cand_q u_cand_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cand_push),
    .wr_data (cand_wr),
    .pop     (cand_pop),
    .rd_data (cand_rd),
    .empty   (cand_empty),
    .full    (full)
  );

  arps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cand              (cand_rd),
    .cand_empty        (cand_empty),
    .cand_pop          (cand_pop),
    .out_center_x      (out_center_x),
    .out_pattern_width (out_pattern_width),
    .empty             (empty),
    .pop               (pop)
  );

endmodule

FILE: sv/arps_front.sv
// Front end: edge phase tracking and run width counting, one pixel per cycle while in_valid is high.
module arps_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic signed [arps_pkg::EDGE_W-1:0] edge_value,
  input  logic [arps_pkg::X_W-1:0] pixel_x,
  input  logic                   row_start,
  output logic                   cand_valid,
  output arps_pkg::cand_t        cand
);
  import arps_pkg::*;

  typedef enum logic [1:0] {PH_WAIT, PH_RUN0, PH_RUN1, PH_RUN2} phase_t;

  phase_t           phase_r, phase_nxt, phase_cur;
  logic [RUN_W-1:0] run0_r, run1_r, run2_r;
  logic [RUN_W-1:0] run0_nxt, run1_nxt, run2_nxt;
  logic [RUN_W-1:0] run0_cur, run1_cur, run2_cur;
  logic             pos, neg, fire;

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    sat_inc = (v < RUN_CAP) ? (v + RUN_W'(1)) : v;
  endfunction

  assign pos = (edge_value != '0) && !edge_value[EDGE_W-1];
  assign neg = edge_value[EDGE_W-1];

  always_comb begin
    phase_cur = row_start ? PH_WAIT : phase_r;
    run0_cur  = row_start ? '0 : run0_r;
    run1_cur  = row_start ? '0 : run1_r;
    run2_cur  = row_start ? '0 : run2_r;
    phase_nxt = phase_cur;
    run0_nxt  = run0_cur;
    run1_nxt  = run1_cur;
    run2_nxt  = run2_cur;
    fire      = 1'b0;
    unique case (phase_cur)
      PH_WAIT: begin
        if (pos) begin
          phase_nxt = PH_RUN0;
          run0_nxt  = sat_inc(run0_cur);
        end
      end
      PH_RUN0: begin
        if (neg) begin
          phase_nxt = PH_RUN1;
          run1_nxt  = sat_inc(run1_cur);
        end else begin
          run0_nxt = sat_inc(run0_cur);
        end
      end
      PH_RUN1: begin
        if (pos) begin
          phase_nxt = PH_RUN2;
          run2_nxt  = sat_inc(run2_cur);
        end else begin
          run1_nxt = sat_inc(run1_cur);
        end
      end
      PH_RUN2: begin
        if (neg) begin
          // third run ends: score, shift runs by two; the run this fall opens holds one pixel already
          fire      = 1'b1;
          phase_nxt = PH_RUN1;
          run0_nxt  = run2_cur;
          run1_nxt  = RUN_W'(1);
          run2_nxt  = '0;
        end else begin
          run2_nxt = sat_inc(run2_cur);
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase
  end

  assign cand_valid    = in_valid && fire;
  assign cand.run_a    = run0_cur;
  assign cand.run_b    = run1_cur;
  assign cand.run_c    = run2_cur;
  assign cand.pixel_x  = pixel_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      run0_r  <= '0;
      run1_r  <= '0;
      run2_r  <= '0;
    end else if (in_valid) begin
      phase_r <= phase_nxt;
      run0_r  <= run0_nxt;
      run1_r  <= run1_nxt;
      run2_r  <= run2_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fire_resume: assert property (@(posedge clk) disable iff (!rst_n)
    cand_valid |=> (phase_r == PH_RUN1) && (run2_r == '0) && (run1_r == RUN_W'(1)))
    else $error("front did not resume at the second run after a candidate");
  a_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT) |-> (run0_r == '0) && (run1_r == '0) && (run2_r == '0))
    else $error("runs counted while waiting for the first rise");
  a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (run0_r <= RUN_CAP) && (run1_r <= RUN_CAP) && (run2_r <= RUN_CAP))
    else $error("run width beyond saturation limit");
`endif

endmodule

FILE: sv/arps_cand_q.sv
// Short candidate queue between the front end and the scoring back end.
module arps_cand_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  arps_pkg::cand_t wr_data,
  input  logic            pop,
  output arps_pkg::cand_t rd_data,
  output logic            empty,
  output logic            full
);
  import arps_pkg::*;

  cand_t            mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_CW-1:0] cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + CQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + CQ_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CQ_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CQ_CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("candidate queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("candidate queue underflow");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("candidate queue pointers disagree with count");
`endif

endmodule

FILE: sv/arps_back.sv
// Back end: three stage candidate scoring pipeline and result queue.
module arps_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  arps_pkg::cfg_t            cfg,
  input  arps_pkg::cand_t           cand,
  input  logic                      cand_empty,
  output logic                      cand_pop,
  output logic [arps_pkg::X_W-1:0]  out_center_x,
  output logic [arps_pkg::SUM_W-1:0] out_pattern_width,
  output logic                      empty,
  input  logic                      pop
);
  import arps_pkg::*;

  // stage 1: sum, centre and nonzero check
  logic               s1_v_r, s1_ok_r;
  logic [RUN_W-1:0]   s1_a_r, s1_b_r, s1_c_r;
  logic [SUM_W-1:0]   s1_sum_r;
  logic [X_W-1:0]     s1_cx_r;
  // stage 2: reciprocal product and finder size test
  logic               s2_v_r, s2_ok_r, s2_fs_hit_r;
  logic [RUN_W-1:0]   s2_a_r, s2_b_r, s2_c_r;
  logic [SUM_W-1:0]   s2_sum_r;
  logic [X_W-1:0]     s2_cx_r;
  logic [PROD_W-1:0]  s2_prod_r;
  // stage 3: verdict
  logic               s3_v_r, s3_pass_r;
  logic [SUM_W-1:0]   s3_sum_r;
  logic [X_W-1:0]     s3_cx_r;

  logic [SUM_W-1:0]   sum0, cx_diff;
  logic [X_W-1:0]     cx0;
  logic [DIFF_W-1:0]  s7, fs3, fs_tol;
  logic [FS_W-3:0]    fs_q;
  logic [SIZE_W-1:0]  size, tol;
  logic [SCORE_W-1:0] score;
  logic               pass;

  // result queue
  logic [X_W-1:0]     rq_cx_r  [RQ_DEPTH];
  logic [SUM_W-1:0]   rq_sum_r [RQ_DEPTH];
  logic [RQ_AW-1:0]   rq_wr_ptr_r, rq_rd_ptr_r;
  logic [RQ_CW-1:0]   rq_cnt_r, inflight;
  logic               rq_wr, rq_rd;

  // Reserve a result slot for every candidate in flight, so the pipeline never stalls
  assign inflight = RQ_CW'(s1_v_r) + RQ_CW'(s2_v_r) + RQ_CW'(s3_v_r);
  assign cand_pop = !cand_empty && ((inflight + rq_cnt_r) < RQ_CW'(RQ_DEPTH));

  always_comb begin
    sum0    = SUM_W'(cand.run_a) + SUM_W'(cand.run_b) + SUM_W'(cand.run_c);
    cx_diff = SUM_W'(cand.pixel_x) - SUM_W'(cand.run_c) - SUM_W'(cand.run_b[RUN_W-1:1]);
    cx0     = cx_diff[SUM_W-1] ? '0 : cx_diff[X_W-1:0];
  end

  always_comb begin
    s7     = DIFF_W'({s1_sum_r, 3'b000}) - DIFF_W'(s1_sum_r);
    fs3    = DIFF_W'({cfg.finder_size, 1'b0}) + DIFF_W'(cfg.finder_size);
    fs_q   = cfg.finder_size[FS_W-1:2];
    fs_tol = DIFF_W'({fs_q, 3'b000}) - DIFF_W'(fs_q);
  end

  always_comb begin
    size  = s2_prod_r[RECIP3_SH +: SIZE_W];
    tol   = size >> 1;
    score = '0;
    if (abs_diff(DIFF_W'(s2_a_r), DIFF_W'(s2_c_r)) < DIFF_W'(tol)) begin
      score = score + SCORE_SYM;
    end
    if (abs_diff(DIFF_W'(size), DIFF_W'(s2_a_r)) < DIFF_W'(tol)) begin
      score = score + SCORE_SIZE;
    end
    if (abs_diff(DIFF_W'(size), DIFF_W'(s2_b_r)) < DIFF_W'(tol)) begin
      score = score + SCORE_SIZE;
    end
    if (abs_diff(DIFF_W'(size), DIFF_W'(s2_c_r)) < DIFF_W'(tol)) begin
      score = score + SCORE_SIZE;
    end
    if (s2_fs_hit_r) begin
      score = score + SCORE_FINDER;
    end
    pass = s2_ok_r && (score > cfg.min_score);
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_a_r      <= cand.run_a;
    s1_b_r      <= cand.run_b;
    s1_c_r      <= cand.run_c;
    s1_sum_r    <= sum0;
    s1_cx_r     <= cx0;
    s1_ok_r     <= (cand.run_a != '0) && (cand.run_b != '0) && (cand.run_c != '0);
    s2_a_r      <= s1_a_r;
    s2_b_r      <= s1_b_r;
    s2_c_r      <= s1_c_r;
    s2_sum_r    <= s1_sum_r;
    s2_cx_r     <= s1_cx_r;
    s2_ok_r     <= s1_ok_r;
    s2_prod_r   <= PROD_W'(s1_sum_r + SUM_W'(1)) * PROD_W'(RECIP3);
    s2_fs_hit_r <= abs_diff(s7, fs3) < fs_tol;
    s3_sum_r    <= s2_sum_r;
    s3_cx_r     <= s2_cx_r;
    s3_pass_r   <= pass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cand_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign rq_wr             = s3_v_r && s3_pass_r;
  assign rq_rd             = pop && !empty;
  assign empty             = (rq_cnt_r == '0);
  assign out_center_x      = rq_cx_r[rq_rd_ptr_r];
  assign out_pattern_width = rq_sum_r[rq_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (rq_wr) begin
      rq_cx_r[rq_wr_ptr_r]  <= s3_cx_r;
      rq_sum_r[rq_wr_ptr_r] <= s3_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_ptr_r <= '0;
      rq_rd_ptr_r <= '0;
      rq_cnt_r    <= '0;
    end else begin
      if (rq_wr) begin
        rq_wr_ptr_r <= rq_wr_ptr_r + RQ_AW'(1);
      end
      if (rq_rd) begin
        rq_rd_ptr_r <= rq_rd_ptr_r + RQ_AW'(1);
      end
      if (rq_wr && !rq_rd) begin
        rq_cnt_r <= rq_cnt_r + RQ_CW'(1);
      end else if (rq_rd && !rq_wr) begin
        rq_cnt_r <= rq_cnt_r - RQ_CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_rq_room: assert property (@(posedge clk) disable iff (!rst_n)
    rq_wr |-> (rq_cnt_r < RQ_CW'(RQ_DEPTH)))
    else $error("result queue overflow");
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight + rq_cnt_r) <= RQ_CW'(RQ_DEPTH))
    else $error("more words in flight than result slots");
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    cand_pop |=> s1_v_r)
    else $error("popped candidate lost before scoring");
`endif

endmodule
